### src/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared codes for the sorted key table
// Command, status and configuration register codes, and the key compare.
// ----------------------------------------------------------------------------
package skt_pkg;

    localparam logic [2:0] CMD_APPEND     = 3'd0;
    localparam logic [2:0] CMD_INSERT     = 3'd1;
    localparam logic [2:0] CMD_REMOVE_KEY = 3'd2;
    localparam logic [2:0] CMD_REMOVE_IDX = 3'd3;
    localparam logic [2:0] CMD_LOOKUP     = 3'd4;
    localparam logic [2:0] CMD_SORT       = 3'd5;
    localparam logic [2:0] CMD_RESET      = 3'd6;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_NOTFOUND = 2'd2;

    localparam logic REG_CAPACITY     = 1'b0;
    localparam logic REG_SIGNED_ORDER = 1'b1;

    // Key compare: less-than under the selected order
    function automatic logic key_lt(input logic [31:0] a, input logic [31:0] b,
                                    input logic sgn);
        logic [31:0] x;
        logic [31:0] y;
        x = a ^ {sgn, 31'd0};
        y = b ^ {sgn, 31'd0};
        return x < y;
    endfunction

endpackage

### src/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: bounded ordered table of 32-bit keys
//
// Input channel (s_axis_*) carries one command item: cmd, key, index.
// Output channel (m_axis_*) returns one result item per command: status,
// found_index, removed_key, entry_count.
// Keys live in a memory of DEPTH entries with one read and one write port; a
// sequencer walks it one read or one write per cycle around its key compares.
// Insert and removes walk the table one entry at a time, lookup probes it by
// halving the search range, and sort is an insertion sort.
// The block takes one item at a time: s_axis_tready is low from acceptance
// until the result register is free again, so the next item can be taken
// in the cycle after the result is accepted.
// When the receiver stalls, the result is held in the output register and
// no new item is taken.
// Reset (i_rst_n low, synchronous) empties the table, sets capacity to 64
// and unsigned order; memory contents need no clearing.
// Configuration writes (i_cfg_we/i_cfg_addr/i_cfg_data) are taken any time.
// ----------------------------------------------------------------------------
module sorted_key_table #(
    parameter int DEPTH = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [2:0] cmd, [34:3] key, [40:35] index, [47:41] zero
    input  logic [47:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [7:2] found_index, [39:8] removed_key,
    // [46:40] entry_count, [47] zero
    output logic [47:0] m_axis_tdata
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (AW > 6) ? AW : 6;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_DISP  = 4'd1;
    localparam logic [3:0] S_INS   = 4'd2;  // read entries[i-1]
    localparam logic [3:0] S_INSW  = 4'd3;  // compare, shift or place
    localparam logic [3:0] S_RKR   = 4'd4;  // read entries[i]
    localparam logic [3:0] S_RKC   = 4'd5;
    localparam logic [3:0] S_GAPR  = 4'd6;  // read entries[i+1]
    localparam logic [3:0] S_GAPW  = 4'd7;
    localparam logic [3:0] S_LKR   = 4'd8;
    localparam logic [3:0] S_LKC   = 4'd9;
    localparam logic [3:0] S_SRTR  = 4'd10; // read v = entries[j]
    localparam logic [3:0] S_SRTV  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [31:0] r_mem [DEPTH];
    logic [31:0] r_rd;

    logic [3:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [6:0]    r_cap;
    logic          r_sgn;
    logic [2:0]    r_cmd;
    logic [31:0]   r_key, n_key;
    logic [IW-1:0] r_idx;
    logic [CW-1:0] r_i, n_i;       // walking position
    logic [CW-1:0] r_j, n_j;       // outer sort position
    logic [CW-1:0] r_lo, n_lo, r_hi, n_hi;
    logic [1:0]    r_st, n_st;
    logic [5:0]    r_fnd, n_fnd;
    logic [31:0]   r_rem, n_rem;
    logic          r_ovld;
    logic [47:0]   r_odata;

    logic          w_we;
    logic [AW-1:0] w_wa, w_ra;
    logic [31:0]   w_wd;
    logic [CW-1:0] w_cap, w_mid;
    logic          w_full;
    logic [CW:0]   w_sum;

    // effective capacity: clamp to 1..DEPTH
    always_comb begin
        if (r_cap == 7'd0) begin
            w_cap = CW'(1);
        end else if (32'(r_cap) > 32'(DEPTH)) begin
            w_cap = CW'(DEPTH);
        end else begin
            w_cap = CW'(r_cap);
        end
    end
    assign w_full = r_count >= w_cap;
    assign w_sum  = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid  = w_sum[CW:1];

    assign s_axis_tready = (r_state == S_IDLE) && !r_ovld;
    assign m_axis_tvalid = r_ovld;
    assign m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_wa] <= w_wd;
        end
        r_rd <= r_mem[w_ra];
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_key   = r_key;
        n_i     = r_i;
        n_j     = r_j;
        n_lo    = r_lo;
        n_hi    = r_hi;
        n_st    = r_st;
        n_fnd   = r_fnd;
        n_rem   = r_rem;
        w_we    = 1'b0;
        w_wa    = r_i[AW-1:0];
        w_wd    = r_key;
        w_ra    = r_i[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_st  = skt_pkg::ST_DONE;
                n_fnd = 6'd0;
                n_rem = 32'd0;
                n_state = S_OUT;
                case (r_cmd)
                    skt_pkg::CMD_APPEND: begin
                        if (w_full) begin
                            n_st = skt_pkg::ST_FULL;
                        end else begin
                            w_we    = 1'b1;
                            w_wa    = r_count[AW-1:0];
                            n_count = r_count + CW'(1);
                        end
                    end
                    skt_pkg::CMD_INSERT: begin
                        if (w_full) begin
                            n_st = skt_pkg::ST_FULL;
                        end else begin
                            n_i     = r_count;
                            n_count = r_count + CW'(1);
                            n_state = S_INS;
                        end
                    end
                    skt_pkg::CMD_REMOVE_KEY: begin
                        n_i     = '0;
                        n_state = S_RKR;
                    end
                    skt_pkg::CMD_REMOVE_IDX: begin
                        if ((IW + 1)'(r_idx) < (IW + 1)'(r_count)) begin
                            n_i     = CW'(r_idx);
                            w_ra    = r_idx[AW-1:0];
                            n_state = S_RKC;
                        end else begin
                            n_st = skt_pkg::ST_NOTFOUND;
                        end
                    end
                    skt_pkg::CMD_LOOKUP: begin
                        n_st    = skt_pkg::ST_NOTFOUND;
                        n_lo    = '0;
                        n_hi    = r_count;
                        n_state = S_LKR;
                    end
                    skt_pkg::CMD_SORT: begin
                        n_j     = CW'(1);
                        n_state = S_SRTR;
                    end
                    skt_pkg::CMD_RESET: begin
                        n_count = '0;
                    end
                    default: begin
                    end
                endcase
            end
            S_INS: begin
                if (r_i == '0) begin
                    w_we    = 1'b1;
                    n_state = (r_cmd == skt_pkg::CMD_SORT) ? S_SRTR : S_OUT;
                    if (r_cmd == skt_pkg::CMD_SORT) begin
                        n_j = r_j + CW'(1);
                    end
                end else begin
                    w_ra    = AW'(r_i - CW'(1));
                    n_state = S_INSW;
                end
            end
            S_INSW: begin
                // r_rd = entries[i-1]; shift up while it sorts above key
                if (skt_pkg::key_lt(r_key, r_rd, r_sgn)) begin
                    w_we  = 1'b1;
                    w_wd  = r_rd;
                    n_i   = r_i - CW'(1);
                    n_state = S_INS;
                end else begin
                    w_we    = 1'b1;
                    n_state = (r_cmd == skt_pkg::CMD_SORT) ? S_SRTR : S_OUT;
                    if (r_cmd == skt_pkg::CMD_SORT) begin
                        n_j = r_j + CW'(1);
                    end
                end
            end
            S_RKR: begin
                if (r_i >= r_count) begin
                    n_st    = skt_pkg::ST_NOTFOUND;
                    n_state = S_OUT;
                end else begin
                    n_state = S_RKC;
                end
            end
            S_RKC: begin
                if (r_cmd == skt_pkg::CMD_REMOVE_IDX || r_rd == r_key) begin
                    n_rem   = r_rd;
                    n_count = r_count - CW'(1);
                    n_state = S_GAPR;
                end else begin
                    n_i     = r_i + CW'(1);
                    w_ra    = AW'(r_i + CW'(1));
                    n_state = S_RKR;
                end
            end
            S_GAPR: begin
                if (r_i >= r_count) begin
                    n_state = S_OUT;
                end else begin
                    w_ra    = AW'(r_i + CW'(1));
                    n_state = S_GAPW;
                end
            end
            S_GAPW: begin
                w_we    = 1'b1;
                w_wd    = r_rd;
                n_i     = r_i + CW'(1);
                n_state = S_GAPR;
            end
            S_LKR: begin
                if (r_hi > r_lo) begin
                    w_ra    = w_mid[AW-1:0];
                    n_i     = w_mid;
                    n_state = S_LKC;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_LKC: begin
                n_state = S_LKR;
                if (r_rd == r_key) begin
                    n_fnd   = 6'(r_i);
                    n_st    = skt_pkg::ST_DONE;
                    n_state = S_OUT;
                end else if (skt_pkg::key_lt(r_rd, r_key, r_sgn)) begin
                    n_lo = r_i + CW'(1);
                end else begin
                    n_hi = r_i;
                end
            end
            S_SRTR: begin
                if (r_j >= r_count) begin
                    n_state = S_OUT;
                end else begin
                    w_ra    = r_j[AW-1:0];
                    n_i     = r_j;
                    n_state = S_SRTV;
                end
            end
            S_SRTV: begin
                // hold v in the key register, then run the insert walk
                n_key   = r_rd;
                n_state = S_INS;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_cap   <= 7'd64;
            r_sgn   <= 1'b0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (i_cfg_we) begin
                if (i_cfg_addr == skt_pkg::REG_CAPACITY) begin
                    r_cap <= i_cfg_data;
                end else begin
                    r_sgn <= i_cfg_data[0];
                end
            end
            if (r_state == S_OUT) begin
                r_ovld <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_cmd <= s_axis_tdata[2:0];
            r_key <= s_axis_tdata[34:3];
            r_idx <= IW'(s_axis_tdata[40:35]);
        end else begin
            r_key <= n_key;
        end
        r_i   <= n_i;
        r_j   <= n_j;
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_st  <= n_st;
        r_fnd <= n_fnd;
        r_rem <= n_rem;
        if (r_state == S_OUT) begin
            r_odata <= {1'b0, 7'(r_count), r_rem, r_fnd, r_st};
        end
    end

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= 32'(DEPTH))
        else $error("entry count above depth");
    a_ready_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !s_axis_tready)
        else $error("ready while busy");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && !m_axis_tready) |=> $stable(r_odata))
        else $error("result changed while stalled");

endmodule

### sim/skt_checker.sv
// ----------------------------------------------------------------------------
// skt_checker: result checker for the sorted key table
// Watches the command and result channels, keeps its own copy of the table,
// predicts one result per accepted command and compares it with the returned result.
// ----------------------------------------------------------------------------
module skt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [6:0]  i_cfg_data,
    input  logic        i_cmd_valid,
    input  logic        i_cmd_ready,
    input  logic [47:0] i_cmd_data,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [47:0] i_res_data,
    output int          o_errors,
    output int          o_pending
);

    localparam int DEPTH = 64;

    logic [31:0] tbl_keys [DEPTH];
    int          tbl_count;
    logic [6:0]  tbl_capacity;
    logic        tbl_signed;
    logic [46:0] result_queue [$];

    function automatic int order_of(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] x;
        logic [31:0] y;
        x = a ^ {tbl_signed, 31'd0};
        y = b ^ {tbl_signed, 31'd0};
        if (x < y) return -1;
        if (x > y) return 1;
        return 0;
    endfunction

    function automatic logic [46:0] table_step(input logic [47:0] item);
        logic [2:0]  cmd;
        logic [31:0] key;
        logic [31:0] v;
        int          idx;
        int          cap;
        int          i;
        int          j;
        int          lo;
        int          hi;
        int          mid;
        int          c;
        logic [1:0]  status;
        logic [5:0]  found;
        logic [31:0] removed;
        cmd = item[2:0];
        key = item[34:3];
        idx = item[40:35];
        status = skt_pkg::ST_DONE;
        found = '0;
        removed = '0;
        cap = tbl_capacity;
        if (cap < 1) cap = 1;
        if (cap > DEPTH) cap = DEPTH;
        case (cmd)
            skt_pkg::CMD_APPEND: begin
                if (tbl_count >= cap) begin
                    status = skt_pkg::ST_FULL;
                end else begin
                    tbl_keys[tbl_count] = key;
                    tbl_count++;
                end
            end
            skt_pkg::CMD_INSERT: begin
                if (tbl_count >= cap) begin
                    status = skt_pkg::ST_FULL;
                end else begin
                    i = tbl_count;
                    tbl_count++;
                    while (i > 0 && order_of(tbl_keys[i-1], key) > 0) begin
                        tbl_keys[i] = tbl_keys[i-1];
                        i--;
                    end
                    tbl_keys[i] = key;
                end
            end
            skt_pkg::CMD_REMOVE_KEY, skt_pkg::CMD_REMOVE_IDX: begin
                status = skt_pkg::ST_NOTFOUND;
                j = -1;
                if (cmd == skt_pkg::CMD_REMOVE_IDX) begin
                    if (idx < tbl_count) j = idx;
                end else begin
                    for (i = tbl_count - 1; i >= 0; i--)
                        if (tbl_keys[i] == key) j = i;
                end
                if (j >= 0) begin
                    status = skt_pkg::ST_DONE;
                    removed = tbl_keys[j];
                    tbl_count--;
                    for (i = j; i < tbl_count; i++) tbl_keys[i] = tbl_keys[i+1];
                end
            end
            skt_pkg::CMD_LOOKUP: begin
                status = skt_pkg::ST_NOTFOUND;
                lo = 0;
                hi = tbl_count;
                while (hi > lo) begin
                    mid = (lo + hi) / 2;
                    c = order_of(key, tbl_keys[mid]);
                    if (c == 0) begin
                        found = mid[5:0];
                        status = skt_pkg::ST_DONE;
                        break;
                    end
                    if (c > 0) lo = mid + 1;
                    else hi = mid;
                end
            end
            skt_pkg::CMD_SORT: begin
                for (i = 1; i < tbl_count; i++) begin
                    v = tbl_keys[i];
                    j = i;
                    while (j > 0 && order_of(v, tbl_keys[j-1]) < 0) begin
                        tbl_keys[j] = tbl_keys[j-1];
                        j--;
                    end
                    tbl_keys[j] = v;
                end
            end
            skt_pkg::CMD_RESET: tbl_count = 0;
            default: ;
        endcase
        return {tbl_count[6:0], removed, found, status};
    endfunction

    assign o_pending = result_queue.size();

    always @(posedge i_clk) begin
        logic [46:0] want;
        if (!i_rst_n) begin
            tbl_count = 0;
            tbl_capacity = 7'd64;
            tbl_signed = 1'b0;
            o_errors <= 0;
            result_queue.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == skt_pkg::REG_CAPACITY) tbl_capacity = i_cfg_data;
                else tbl_signed = i_cfg_data[0];
            end
            if (i_cmd_valid && i_cmd_ready) result_queue.push_back(table_step(i_cmd_data));
            if (i_res_valid && i_res_ready) begin
                if (result_queue.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, i_res_data);
                    o_errors <= o_errors + 1;
                end else begin
                    want = result_queue.pop_front();
                    if (i_res_data[46:0] !== want || i_res_data[47] !== 1'b0) begin
                        $display("%0t: mismatch expected st=%0d idx=%0d rm=%h cnt=%0d",
                                 $time, want[1:0], want[7:2], want[39:8], want[46:40]);
                        $display("%0t:           actual st=%0d idx=%0d rm=%h cnt=%0d",
                                 $time, i_res_data[1:0], i_res_data[7:2],
                                 i_res_data[39:8], i_res_data[46:40]);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule

### sim/tb_sorted_key_table.sv
// ----------------------------------------------------------------------------
// tb_sorted_key_table: stimulus and verdict for the sorted key table
// Drives directed then random command items under random gaps and stalls,
// walks several capacity and order settings, and reports the checker result.
// ----------------------------------------------------------------------------
module tb_sorted_key_table;

    localparam int LIMIT = 3000000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_addr = 1'b0;
    logic [6:0]  cfg_data = '0;
    logic        cmd_valid = 1'b0;
    logic        cmd_ready;
    logic [47:0] cmd_data = '0;
    logic        res_valid;
    logic        res_ready = 1'b0;
    logic [47:0] res_data;
    int          errors;
    int          pending;
    int          cycles = 0;
    int          sent = 0;
    logic [31:0] recent_keys [8];

    always #1 i_clk = ~i_clk;

    wire m_ready_w = res_ready;

    sorted_key_table uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .s_axis_tvalid(cmd_valid), .s_axis_tready(cmd_ready), .s_axis_tdata(cmd_data),
        .m_axis_tvalid(res_valid), .m_axis_tready(m_ready_w), .m_axis_tdata(res_data)
    );

    skt_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_addr(cfg_addr), .i_cfg_data(cfg_data),
        .i_cmd_valid(cmd_valid), .i_cmd_ready(cmd_ready), .i_cmd_data(cmd_data),
        .i_res_valid(res_valid), .i_res_ready(m_ready_w), .i_res_data(res_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // random receiver stalls, with calm stretches
    initial begin
        int wait_n;
        forever begin
            @(negedge i_clk);
            wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
            res_ready <= 1'b0;
            repeat (wait_n) @(negedge i_clk);
            res_ready <= 1'b1;
            do @(posedge i_clk); while (!res_valid);
        end
    end

    task automatic send_cmd(input logic [2:0] cmd, input logic [31:0] key,
                            input logic [5:0] idx);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        repeat (gap) @(negedge i_clk);
        cmd_data <= {7'd0, idx, key, cmd};
        cmd_valid <= 1'b1;
        do @(posedge i_clk); while (!cmd_ready);
        @(negedge i_clk);
        cmd_valid <= 1'b0;
        recent_keys[sent % 8] = key;
        sent++;
    endtask

    task automatic write_reg(input logic addr, input logic [6:0] value);
        while (pending != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        cfg_we <= 1'b1;
        cfg_addr <= addr;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    // mostly fill-and-query traffic, with keys reused so removes and lookups hit
    task automatic random_phase(input int n);
        int          k;
        int          r;
        logic [31:0] key;
        for (k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (sent > 8 && $urandom_range(0, 1)) key = recent_keys[$urandom_range(0, 7)];
            else if ($urandom_range(0, 2) == 0) key = $urandom_range(0, 15) - 8;
            else key = $urandom;
            if (r < 25) send_cmd(skt_pkg::CMD_INSERT, key, 6'($urandom));
            else if (r < 40) send_cmd(skt_pkg::CMD_APPEND, key, 6'($urandom));
            else if (r < 52) send_cmd(skt_pkg::CMD_REMOVE_KEY, key, 6'($urandom));
            else if (r < 62) send_cmd(skt_pkg::CMD_REMOVE_IDX, key,
                                      6'($urandom_range(0, 20)));
            else if (r < 66) send_cmd(skt_pkg::CMD_REMOVE_IDX, key, 6'($urandom));
            else if (r < 88) send_cmd(skt_pkg::CMD_LOOKUP, key, 6'($urandom));
            else if (r < 94) send_cmd(skt_pkg::CMD_SORT, key, 6'($urandom));
            else if (r < 96) send_cmd(skt_pkg::CMD_RESET, key, 6'($urandom));
            else send_cmd(3'd7, key, 6'($urandom));
        end
    endtask

    initial begin
        int p;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: empty table, extremes, every command
        send_cmd(skt_pkg::CMD_LOOKUP, 32'h0, 6'd0);
        send_cmd(skt_pkg::CMD_REMOVE_KEY, 32'h0, 6'd0);
        send_cmd(skt_pkg::CMD_REMOVE_IDX, 32'h0, 6'd63);
        send_cmd(skt_pkg::CMD_SORT, 32'h0, 6'd0);
        send_cmd(skt_pkg::CMD_APPEND, 32'hFFFF_FFFF, 6'd63);
        send_cmd(skt_pkg::CMD_APPEND, 32'h0, 6'd0);
        send_cmd(skt_pkg::CMD_APPEND, 32'h8000_0000, 6'd0);
        send_cmd(skt_pkg::CMD_APPEND, 32'h7FFF_FFFF, 6'd0);
        send_cmd(skt_pkg::CMD_LOOKUP, 32'h0, 6'd0);
        send_cmd(skt_pkg::CMD_SORT, 32'h0, 6'd0);
        send_cmd(skt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0);
        send_cmd(skt_pkg::CMD_INSERT, 32'h7FFF_FFFF, 6'd0);
        send_cmd(skt_pkg::CMD_INSERT, 32'h1, 6'd0);
        send_cmd(skt_pkg::CMD_REMOVE_IDX, 32'h0, 6'd5);
        send_cmd(skt_pkg::CMD_REMOVE_IDX, 32'h0, 6'd6);
        send_cmd(skt_pkg::CMD_REMOVE_KEY, 32'h7FFF_FFFF, 6'd0);
        send_cmd(skt_pkg::CMD_REMOVE_KEY, 32'h1234_5678, 6'd0);
        send_cmd(3'd7, 32'hFFFF_FFFF, 6'd63);
        send_cmd(skt_pkg::CMD_RESET, 32'h0, 6'd0);

        // full table at tiny capacity, then capacity zero and above range
        write_reg(skt_pkg::REG_CAPACITY, 7'd2);
        write_reg(skt_pkg::REG_SIGNED_ORDER, 7'd1);
        send_cmd(skt_pkg::CMD_INSERT, 32'hFFFF_FFFF, 6'd0);
        send_cmd(skt_pkg::CMD_INSERT, 32'h0000_0001, 6'd0);
        send_cmd(skt_pkg::CMD_APPEND, 32'h5, 6'd0);
        send_cmd(skt_pkg::CMD_LOOKUP, 32'hFFFF_FFFF, 6'd0);
        write_reg(skt_pkg::REG_CAPACITY, 7'd0);
        send_cmd(skt_pkg::CMD_INSERT, 32'h5, 6'd0);
        send_cmd(skt_pkg::CMD_REMOVE_IDX, 32'h0, 6'd0);
        send_cmd(skt_pkg::CMD_REMOVE_IDX, 32'h0, 6'd0);
        send_cmd(skt_pkg::CMD_APPEND, 32'h5, 6'd0);

        for (p = 0; p < 8; p++) begin
            case (p % 4)
                0: write_reg(skt_pkg::REG_CAPACITY, 7'd127);
                1: write_reg(skt_pkg::REG_CAPACITY, 7'd1);
                2: write_reg(skt_pkg::REG_CAPACITY, 7'd64);
                default: write_reg(skt_pkg::REG_CAPACITY, 7'($urandom_range(1, 30)));
            endcase
            write_reg(skt_pkg::REG_SIGNED_ORDER, 7'(p % 2));
            random_phase(100);
        end

        while (pending != 0) @(negedge i_clk);
        repeat (50) @(negedge i_clk);
        $display("Ran %0d command items over capacities 0 to 127, signed and unsigned",
                 sent);
        $display("order, with random gaps and stalls on both channels.");
        if (errors == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### filelist.f
src/skt_pkg.sv
src/sorted_key_table.sv
sim/skt_checker.sv
sim/tb_sorted_key_table.sv
